// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the ribbon trail rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RTD_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ribbon trail: same-cycle check failed");

// next-cycle implication, disabled during reset
`define RTD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ribbon trail: next-cycle check failed");

`endif

// File: rtl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// types, constants and helpers shared by the ribbon trail vertex generator
// ----------------------------------------------------------------------------
package rtd_pkg;

  // vector widths through the normaliser
  localparam int VW   = 35;  // signed input vector component
  localparam int NW   = 18;  // signed unit component, q1.16
  localparam int SUMW = 62;  // sum of squares
  localparam int LENW = 31;  // vector length
  localparam int ADDR_W = 5;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CAM_X = 3'd0;
  localparam logic [2:0] REG_CAM_Y = 3'd1;
  localparam logic [2:0] REG_CAM_Z = 3'd2;
  localparam logic [2:0] REG_WIDTH = 3'd3;
  localparam logic [2:0] REG_COUNT = 3'd4;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic [30:0]        width;
    logic [8:0]         count;
  } rtd_cfg_t;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SHIFT,
    NS_SQ,
    NS_SQRT,
    NS_DSTART,
    NS_DWAIT,
    NS_FIN
  } norm_state_t;

  typedef enum logic [3:0] {
    T_IDLE,
    T_NDIR,
    T_NDIR_W,
    T_NCAM,
    T_NCAM_W,
    T_CROSS,
    T_NCR,
    T_NCR_W,
    T_OFF,
    T_U,
    T_U_W,
    T_EMIT_L,
    T_EMIT_R
  } top_state_t;

  // clamp a 34-bit signed sum into the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/ribbon_trail_vertex_gen.sv
// ----------------------------------------------------------------------------
// ribbon_trail_vertex_gen
// camera-facing ribbon trail: turns a stream of trail points into vertex pairs
// ----------------------------------------------------------------------------
// The first point of a run gives no vertex. Every later point gives the left
// and right vertices of the point before it, and the last point of a run also
// gives its own pair; each pair runs three normalisations through one sequenced
// normaliser (square root and divide at one bit a cycle), six cross products
// and three offsets through one shared multiplier, and a divide for the texture
// coordinate. A finished vertex waits in the output register, and a new point
// is taken while the last vertex of the previous one is pending.
`include "assert_macros.svh"

module ribbon_trail_vertex_gen #(
  parameter int MAX_POINTS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  input  logic [95:0]                 in_tdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // vertex_x [31:0], vertex_y [63:32], vertex_z [95:64], fade_alpha [103:96],
  // tex_u [120:104], zero fill [127:121]
  output logic [127:0]                out_tdata,
  // right_side
  output logic                        out_tuser,
  output logic                        out_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rtd_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import rtd_pkg::*;

  localparam int IW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  rtd_cfg_t   cfg;
  top_state_t st_r, st_nxt;

  logic [2:0][31:0]   held_r, pt_r;
  logic [2:0][32:0]   dir_r;
  logic [IW-1:0]      index_r, emit_idx_r, idx_acc_r;
  logic               run_end_r, second_r;
  logic [2:0][NW-1:0] nd_r, nc_r, rv_r;
  logic [2:0][VW-1:0] cr_r;
  logic [2:0][31:0]   off_r;
  logic signed [50:0] prod_r;
  logic [2:0]         cnt_r;
  logic [16:0]        u_r;

  logic               accept, out_free, load_l, load_r;
  logic [IW-1:0]      last_idx, u_num;
  logic [31:0]        cnt32, lastw;
  logic               norm_start, norm_done;
  logic [2:0][VW-1:0] norm_vec;
  logic [2:0][NW-1:0] norm_res;
  logic               udiv_start, udiv_done;
  logic [16:0]        udiv_q;
  logic signed [18:0] mul_a;
  logic signed [31:0] mul_b;
  logic [2:0]         j_acc;
  logic [16:0]        alpha_t;
  logic [24:0]        alpha_w;
  logic [2:0][31:0]   vert_l, vert_r;
  logic [2:0][31:0]   vert_sel;

  logic [31:0]        out_x_r, out_y_r, out_z_r;
  logic [7:0]         out_alpha_r;
  logic [16:0]        out_u_r;
  logic               out_side_r, out_last_r, out_valid_r;

  rtd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // effective run length, clamped to the supported range
  always_comb begin
    cnt32 = 32'(cfg.count);
    if (cnt32 < 32'd2) begin
      lastw = 32'd1;
    end else if (cnt32 > 32'(MAX_POINTS)) begin
      lastw = 32'(MAX_POINTS - 1);
    end else begin
      lastw = cnt32 - 32'd1;
    end
    last_idx = lastw[IW-1:0];
    u_num    = (emit_idx_r > last_idx) ? last_idx : emit_idx_r;
  end

  // normaliser operand select
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      norm_vec[k] = '0;
    end
    unique case (st_r)
      T_NDIR: begin
        for (int k = 0; k < 3; k++) norm_vec[k] = VW'($signed(dir_r[k]));
      end
      T_NCAM: begin
        norm_vec[0] = VW'($signed({cfg.cam_x[31], cfg.cam_x}) - $signed({pt_r[0][31], pt_r[0]}));
        norm_vec[1] = VW'($signed({cfg.cam_y[31], cfg.cam_y}) - $signed({pt_r[1][31], pt_r[1]}));
        norm_vec[2] = VW'($signed({cfg.cam_z[31], cfg.cam_z}) - $signed({pt_r[2][31], pt_r[2]}));
      end
      default: begin
        for (int k = 0; k < 3; k++) norm_vec[k] = cr_r[k];
      end
    endcase
  end

  rtd_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vec   (norm_vec),
    .res   (norm_res),
    .done  (norm_done)
  );

  rtd_div #(.DW(IW)) u_udiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (udiv_start),
    .num   (u_num),
    .den   (last_idx),
    .done  (udiv_done),
    .quo   (udiv_q)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st_r == T_OFF) begin
      unique case (cnt_r)
        3'd0:    mul_a = {2'b00, rv_r[0][NW-1] ? 17'(-rv_r[0]) : rv_r[0][16:0]};
        3'd1:    mul_a = {2'b00, rv_r[1][NW-1] ? 17'(-rv_r[1]) : rv_r[1][16:0]};
        default: mul_a = {2'b00, rv_r[2][NW-1] ? 17'(-rv_r[2]) : rv_r[2][16:0]};
      endcase
      mul_b = {1'b0, cfg.width};
    end else begin
      unique case (cnt_r)
        3'd0: begin mul_a = 19'($signed(nd_r[1])); mul_b = 32'($signed(nc_r[2])); end
        3'd1: begin mul_a = 19'($signed(nd_r[2])); mul_b = 32'($signed(nc_r[1])); end
        3'd2: begin mul_a = 19'($signed(nd_r[2])); mul_b = 32'($signed(nc_r[0])); end
        3'd3: begin mul_a = 19'($signed(nd_r[0])); mul_b = 32'($signed(nc_r[2])); end
        3'd4: begin mul_a = 19'($signed(nd_r[0])); mul_b = 32'($signed(nc_r[1])); end
        default: begin mul_a = 19'($signed(nd_r[1])); mul_b = 32'($signed(nc_r[0])); end
      endcase
    end
    j_acc = cnt_r - 3'd1;
  end

  // vertex positions and fade
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vert_l[k] = sat32($signed({{2{pt_r[k][31]}}, pt_r[k]}) -
                        $signed({{2{off_r[k][31]}}, off_r[k]}));
      vert_r[k] = sat32($signed({{2{pt_r[k][31]}}, pt_r[k]}) +
                        $signed({{2{off_r[k][31]}}, off_r[k]}));
    end
    vert_sel = (st_r == T_EMIT_R) ? vert_r : vert_l;
    alpha_t  = 17'd65536 - u_r;
    alpha_w  = {alpha_t, 8'd0} - 25'(alpha_t);
  end

  assign in_tready = (st_r == T_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // sequencer
  always_comb begin
    st_nxt     = st_r;
    norm_start = 1'b0;
    udiv_start = 1'b0;
    load_l     = 1'b0;
    load_r     = 1'b0;
    unique case (st_r)
      T_IDLE:   if (accept && index_r != '0) st_nxt = T_NDIR;
      T_NDIR:   begin norm_start = 1'b1; st_nxt = T_NDIR_W; end
      T_NDIR_W: if (norm_done) st_nxt = T_NCAM;
      T_NCAM:   begin norm_start = 1'b1; st_nxt = T_NCAM_W; end
      T_NCAM_W: if (norm_done) st_nxt = T_CROSS;
      T_CROSS:  if (cnt_r == 3'd6) st_nxt = T_NCR;
      T_NCR:    begin norm_start = 1'b1; st_nxt = T_NCR_W; end
      T_NCR_W:  if (norm_done) st_nxt = T_OFF;
      T_OFF:    if (cnt_r == 3'd3) st_nxt = T_U;
      T_U:      begin udiv_start = 1'b1; st_nxt = T_U_W; end
      T_U_W:    if (udiv_done) st_nxt = T_EMIT_L;
      T_EMIT_L: if (out_free) begin load_l = 1'b1; st_nxt = T_EMIT_R; end
      T_EMIT_R: begin
        if (out_free) begin
          load_r = 1'b1;
          st_nxt = (run_end_r && !second_r) ? T_NDIR : T_IDLE;
        end
      end
      default:  st_nxt = T_IDLE;
    endcase
  end

  // trail state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
      held_r  <= '0;
    end else if (accept) begin
      for (int k = 0; k < 3; k++) held_r[k] <= in_tdata[32*k +: 32];
      if (index_r == '0) begin
        index_r <= IW'(1);
      end else if (index_r >= last_idx) begin
        index_r <= '0;
      end else begin
        index_r <= index_r + IW'(1);
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (accept && index_r != '0) begin
      for (int k = 0; k < 3; k++) begin
        pt_r[k]  <= held_r[k];
        dir_r[k] <= 33'($signed({in_tdata[32*k+31], in_tdata[32*k +: 32]}) -
                        $signed({held_r[k][31], held_r[k]}));
      end
      emit_idx_r <= index_r - IW'(1);
      idx_acc_r  <= index_r;
      run_end_r  <= index_r >= last_idx;
      second_r   <= 1'b0;
    end
    if (load_r && run_end_r && !second_r) begin
      pt_r       <= held_r;
      emit_idx_r <= idx_acc_r;
      second_r   <= 1'b1;
    end
    if (st_r == T_NDIR_W && norm_done) nd_r <= norm_res;
    if (st_r == T_NCAM_W && norm_done) nc_r <= norm_res;
    if (st_r == T_NCR_W && norm_done)  rv_r <= norm_res;
    if (st_r == T_U_W && udiv_done)    u_r  <= udiv_q;

    // cross products and offsets share one multiplier, each product accumulated in the next cycle
    if (st_r == T_CROSS || st_r == T_OFF) begin
      prod_r <= mul_a * mul_b;
      cnt_r  <= cnt_r + 3'd1;
    end else begin
      cnt_r  <= '0;
    end
    if (st_r == T_CROSS && cnt_r != 3'd0) begin
      if (!j_acc[0]) begin
        cr_r[j_acc[2:1]] <= VW'(prod_r);
      end else begin
        cr_r[j_acc[2:1]] <= cr_r[j_acc[2:1]] - VW'(prod_r);
      end
    end
    if (st_r == T_OFF && cnt_r != 3'd0) begin
      off_r[j_acc[1:0]] <= rv_r[j_acc[1:0]][NW-1] ? 32'(-{1'b0, prod_r[47:17]})
                                                 : {1'b0, prod_r[47:17]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_l || load_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_l || load_r) begin
      out_x_r     <= vert_sel[0];
      out_y_r     <= vert_sel[1];
      out_z_r     <= vert_sel[2];
      out_alpha_r <= alpha_w[23:16];
      out_u_r     <= u_r;
      out_side_r  <= load_r;
      out_last_r  <= load_r & run_end_r & second_r;
    end
  end

  assign out_tdata  = {7'd0, out_u_r, out_alpha_r, out_z_r, out_y_r, out_x_r};
  assign out_tuser  = out_side_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

  // checks
  `RTD_ASSERT_IMPL(a_norm_done_wait, clk, rst_n, norm_done,
    st_r == T_NDIR_W || st_r == T_NCAM_W || st_r == T_NCR_W)
  `RTD_ASSERT_IMPL(a_udiv_done_wait, clk, rst_n, udiv_done, st_r == T_U_W)
  `RTD_ASSERT_NEXT(a_pair_starts, clk, rst_n, accept && index_r != '0, st_r == T_NDIR)
endmodule

// File: rtl/rtd_div.sv
// ----------------------------------------------------------------------------
// rtd_div
// restoring divider, q = floor(num * 2^16 / den) for num <= den, one bit a cycle
// ----------------------------------------------------------------------------
module rtd_div #(
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [16:0]   quo
);
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [16:0]   q_r;
  logic [4:0]    cnt_r;
  logic          busy_r, done_r;
  logic          ge;
  logic [DW:0]   rem_sub;

  // one compare and subtract step
  always_comb begin
    ge      = rem_r >= {1'b0, den_r};
    rem_sub = ge ? rem_r - {1'b0, den_r} : rem_r;
    rem_nxt = {rem_sub[DW-1:0], 1'b0};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd17;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[15:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

// File: rtl/rtd_norm.sv
// ----------------------------------------------------------------------------
// rtd_norm
// sequenced vector normaliser: range shift, sum of squares, square root, divide
// ----------------------------------------------------------------------------
module rtd_norm (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [2:0][rtd_pkg::VW-1:0]      vec,
  output logic [2:0][rtd_pkg::NW-1:0]      res,
  output logic                             done
);
  import rtd_pkg::*;

  norm_state_t st_r, st_nxt;
  logic [2:0][VW-1:0] m_r;
  logic [2:0]         neg_r;
  logic [2:0][NW-1:0] res_r;
  logic [SUMW-1:0]    sum_r, x_r, root_r, bit_r;
  logic [59:0]        sq_r;
  logic [1:0]         cnt_r;
  logic [29:0]        sq_src;
  logic [SUMW-1:0]    trial;
  logic               big;
  logic [LENW-1:0]    len;
  logic               div_start, div_done;
  logic [16:0]        div_q;

  assign len = root_r[LENW-1:0];

  always_comb begin
    big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      big = big | (|m_r[k][VW-1:30]);
    end
    unique case (cnt_r)
      2'd0:    sq_src = m_r[0][29:0];
      2'd1:    sq_src = m_r[1][29:0];
      default: sq_src = m_r[2][29:0];
    endcase
    trial = root_r + bit_r;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= NS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // next state and strobes
  always_comb begin
    st_nxt    = st_r;
    div_start = 1'b0;
    unique case (st_r)
      NS_IDLE:   if (start) st_nxt = NS_SHIFT;
      NS_SHIFT:  if (!big) st_nxt = NS_SQ;
      NS_SQ:     if (cnt_r == 2'd3) st_nxt = NS_SQRT;
      NS_SQRT:   if (bit_r[0]) st_nxt = NS_DSTART;
      NS_DSTART: begin
        if (len == '0) begin
          st_nxt = NS_FIN;
        end else begin
          div_start = 1'b1;
          st_nxt    = NS_DWAIT;
        end
      end
      NS_DWAIT:  if (div_done) st_nxt = (cnt_r == 2'd2) ? NS_FIN : NS_DSTART;
      NS_FIN:    st_nxt = NS_IDLE;
      default:   st_nxt = NS_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      NS_IDLE: begin
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= vec[k][VW-1];
          m_r[k]   <= vec[k][VW-1] ? VW'(-vec[k]) : vec[k];
          res_r[k] <= '0;
        end
        sum_r <= '0;
        cnt_r <= '0;
      end
      NS_SHIFT: begin
        if (big) begin
          for (int k = 0; k < 3; k++) begin
            m_r[k] <= m_r[k] >> 1;
          end
        end
      end
      NS_SQ: begin
        sq_r  <= sq_src * sq_src;
        if (cnt_r != 2'd0) sum_r <= sum_r + SUMW'(sq_r);
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          x_r    <= sum_r + SUMW'(sq_r);
          root_r <= '0;
          bit_r  <= SUMW'(1) << 60;
        end
      end
      NS_SQRT: begin
        if (x_r >= trial) begin
          x_r    <= x_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= '0;
      end
      NS_DWAIT: begin
        if (div_done) begin
          res_r[cnt_r] <= neg_r[cnt_r] ? NW'(-{1'b0, div_q}) : NW'({1'b0, div_q});
          cnt_r        <= cnt_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  rtd_div #(.DW(LENW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (m_r[cnt_r][LENW-1:0]),
    .den   (len),
    .done  (div_done),
    .quo   (div_q)
  );

  assign res  = res_r;
  assign done = (st_r == NS_FIN);
endmodule

// File: rtl/rtd_cfg.sv
// ----------------------------------------------------------------------------
// rtd_cfg
// apb register file: camera position, ribbon width, point count
// ----------------------------------------------------------------------------
module rtd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rtd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rtd_pkg::rtd_cfg_t           cfg
);
  import rtd_pkg::*;

  rtd_cfg_t   cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_x <= '0;
      cfg_r.cam_y <= '0;
      cfg_r.cam_z <= '0;
      cfg_r.width <= 31'd65536;
      cfg_r.count <= 9'd2;
    end else if (wr) begin
      unique case (idx)
        REG_CAM_X: cfg_r.cam_x <= pwdata;
        REG_CAM_Y: cfg_r.cam_y <= pwdata;
        REG_CAM_Z: cfg_r.cam_z <= pwdata;
        REG_WIDTH: cfg_r.width <= pwdata[30:0];
        REG_COUNT: cfg_r.count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_CAM_X: prdata = cfg_r.cam_x;
      REG_CAM_Y: prdata = cfg_r.cam_y;
      REG_CAM_Z: prdata = cfg_r.cam_z;
      REG_WIDTH: prdata = {1'b0, cfg_r.width};
      REG_COUNT: prdata = {23'd0, cfg_r.count};
      default:   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;
endmodule
